/* design/lprd_pkg.sv */
// Shared types and constants for the length-prefixed request deframer.
`default_nettype none

package lprd_pkg;

    // Width of body and argument length counters.
    localparam int LENGTH_WIDTH = 24;
    localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

    // Every length or count header is four little-endian bytes.
    localparam int HDR_BYTES = 4;

    localparam int MAX_LEN_W  = 24;
    localparam int MAX_ARGS_W = 16;
    localparam int ARG_IDX_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RESET  = MAX_LEN_W'(4096);
    localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RESET = MAX_ARGS_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS = 1'b1;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_CNT,
        PH_ALEN,
        PH_DATA,
        PH_CLOSED
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TOO_LONG,
        ST_TOO_SHORT,
        ST_TOO_MANY_ARGS,
        ST_ARG_OVERRUN,
        ST_TRAILING,
        ST_CLOSED
    } status_t;

    typedef struct packed {
        logic                 data_valid;
        logic [7:0]           arg_byte;
        logic [ARG_IDX_W-1:0] arg_index;
        logic                 arg_end;
        logic                 request_end;
        status_t              status;
    } result_t;

endpackage

`default_nettype wire

/* design/lprd_parser.sv */
// Request parse state and the per-beat next-state and result logic.
`default_nettype none

module lprd_parser
    import lprd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  restart,
    input  wire logic [MAX_LEN_W-1:0]  max_message_len,
    input  wire logic [MAX_ARGS_W-1:0] max_arg_count,
    output result_t                    res,
    output logic                       closed
);

    phase_t                  phase_reg, phase_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [31:0]             shift_reg, shift_next;
    logic [LENGTH_WIDTH-1:0] body_reg, body_next;
    logic [ARG_IDX_W-1:0]    args_reg, args_next;
    logic [ARG_IDX_W-1:0]    idx_reg, idx_next;
    logic [LENGTH_WIDTH-1:0] alen_reg, alen_next;

    logic [31:0]             shift_acc;
    logic [31:0]             hdr_val;
    logic                    hdr_done;
    logic [LENGTH_WIDTH-1:0] body_dec;
    logic [LENGTH_WIDTH-1:0] alen_dec;
    logic                    after;
    logic [ARG_IDX_W-1:0]    args_after;
    status_t                 st;

    assign shift_acc = shift_reg | (32'(in_byte) << {cnt_reg, 3'b000});
    assign hdr_val   = {in_byte, shift_reg[23:0]};
    assign hdr_done  = (cnt_reg == 2'd3);
    assign body_dec  = body_reg - LENGTH_WIDTH'(1);
    assign alen_dec  = alen_reg - LENGTH_WIDTH'(1);
    assign closed    = (phase_reg == PH_CLOSED);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        body_next  = body_reg;
        args_next  = args_reg;
        idx_next   = idx_reg;
        alen_next  = alen_reg;
        after      = 1'b0;
        args_after = args_reg;
        st         = ST_OK;
        res             = '0;
        res.arg_index   = idx_reg;

        if (restart)
        begin
            phase_next    = PH_LEN;
            cnt_next      = 2'd0;
            shift_next    = '0;
            body_next     = '0;
            args_next     = '0;
            idx_next      = '0;
            alen_next     = '0;
            res.arg_index = '0;
        end
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    cnt_next   = cnt_reg + 2'd1;
                    shift_next = hdr_done ? 32'd0 : shift_acc;
                    if (hdr_done)
                    begin
                        if (hdr_val > 32'(max_message_len) || hdr_val > LEN_MAX)
                            st = ST_TOO_LONG;
                        else if (hdr_val < 32'(HDR_BYTES))
                            st = ST_TOO_SHORT;
                        else
                        begin
                            body_next  = hdr_val[LENGTH_WIDTH-1:0];
                            phase_next = PH_CNT;
                        end
                    end
                end
                PH_CNT:
                begin
                    body_next  = body_dec;
                    cnt_next   = cnt_reg + 2'd1;
                    shift_next = hdr_done ? 32'd0 : shift_acc;
                    if (hdr_done)
                    begin
                        if (hdr_val > 32'(max_arg_count))
                            st = ST_TOO_MANY_ARGS;
                        else
                        begin
                            args_after = hdr_val[ARG_IDX_W-1:0];
                            args_next  = args_after;
                            idx_next   = '0;
                            after      = 1'b1;
                        end
                    end
                end
                PH_ALEN:
                begin
                    body_next  = body_dec;
                    cnt_next   = cnt_reg + 2'd1;
                    shift_next = hdr_done ? 32'd0 : shift_acc;
                    if (hdr_done)
                    begin
                        if (hdr_val > 32'(body_dec))
                            st = ST_ARG_OVERRUN;
                        else if (hdr_val == 32'd0)
                        begin
                            // empty argument ends on its last length byte
                            res.arg_end = 1'b1;
                            args_after  = args_reg - ARG_IDX_W'(1);
                            args_next   = args_after;
                            idx_next    = idx_reg + ARG_IDX_W'(1);
                            after       = 1'b1;
                        end
                        else
                        begin
                            alen_next  = hdr_val[LENGTH_WIDTH-1:0];
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    res.data_valid = 1'b1;
                    res.arg_byte   = in_byte;
                    body_next      = body_dec;
                    alen_next      = alen_dec;
                    if (alen_dec == '0)
                    begin
                        res.arg_end = 1'b1;
                        args_after  = args_reg - ARG_IDX_W'(1);
                        args_next   = args_after;
                        idx_next    = idx_reg + ARG_IDX_W'(1);
                        after       = 1'b1;
                    end
                end
                default:
                begin
                    st = ST_CLOSED;
                end
            endcase

            // what follows a finished count header or argument
            if (after)
            begin
                if (args_after == '0)
                begin
                    if (body_dec == '0)
                    begin
                        res.request_end = 1'b1;
                        phase_next      = PH_LEN;
                        idx_next        = '0;
                    end
                    else
                        st = ST_TRAILING;
                end
                else if (body_dec < LENGTH_WIDTH'(HDR_BYTES))
                    st = ST_ARG_OVERRUN;
                else
                    phase_next = PH_ALEN;
            end

            if (st != ST_OK)
                phase_next = PH_CLOSED;
        end

        res.status = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            cnt_reg   <= 2'd0;
            shift_reg <= '0;
            body_reg  <= '0;
            args_reg  <= '0;
            idx_reg   <= '0;
            alen_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            body_reg  <= body_next;
            args_reg  <= args_next;
            idx_reg   <= idx_next;
            alen_reg  <= alen_next;
        end
    end

endmodule

`default_nettype wire

/* design/length_prefixed_request_deframer_unit.sv */
// An accepted input beat is held in the input register; its result is then registered in the result register.
// Throughput: one byte per cycle while the output is not stalled; the parse state updates as a beat
// moves from the input register to the result register.
// Reset: rst_n is asynchronous, active low; parser returns to waiting for a
// body length, limits return to 4096 bytes and 1024 arguments.
`default_nettype none

module length_prefixed_request_deframer_unit
    import lprd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] in_byte
    input  wire logic                  s_tuser,   // [0] restart
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] arg_byte, [23:8] arg_index, [24] request_end, [27:25] status, [31:28] zero
    output logic [31:0]                m_tdata,
    output logic                       m_tuser,   // [0] data_valid
    output logic                       m_tlast,   // arg_end
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MAX_LEN_W-1:0]  max_len_reg;
    logic [MAX_ARGS_W-1:0] max_args_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    result_t    res;
    logic       closed;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= MAX_LEN_RESET;
            max_args_reg <= MAX_ARGS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_LEN:  max_len_reg  <= cfg_data[MAX_LEN_W-1:0];
                REG_MAX_ARGS: max_args_reg <= cfg_data[MAX_ARGS_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
    end

    lprd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .in_byte         (in_byte_reg),
        .restart         (in_restart_reg),
        .max_message_len (max_len_reg),
        .max_arg_count   (max_args_reg),
        .res             (res),
        .closed          (closed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.data_valid;
    assign m_tlast  = out_reg.arg_end;
    assign m_tdata  = {4'b0000, out_reg.status, out_reg.request_end,
                       out_reg.arg_index, out_reg.arg_byte};

    // a completed request never carries an error
    a_req_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.request_end |-> out_reg.status == ST_OK)
        else $error("request_end with error status");

    // a held input beat stays put while the output stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_restart_reg))
        else $error("input register changed while stalled");

    // any flagged error leaves the parser closed
    a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.status != ST_OK |=> closed)
        else $error("parser not closed after error");

    // restart clears the argument index
    a_restart_idx: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_restart_reg |=> res.arg_index == '0)
        else $error("argument index not cleared by restart");

endmodule

`default_nettype wire

/* bench/length_prefixed_request_deframer_unit_test.sv */
// Self-checking bench for the request deframer: byte stream in, parse-result beats out.

module length_prefixed_request_deframer_unit_test;
    import lprd_pkg::*;

    typedef enum int {
        F_NONE,
        F_TOO_LONG,
        F_TOO_SHORT,
        F_TOO_MANY,
        F_ARG_OVERRUN,
        F_SHORT_BODY,
        F_TRAILING,
        F_RESTART_MID,
        F_NOISE
    } fault_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_LEN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Parser mirror
    phase_t                ph = PH_LEN;
    logic [1:0]            hdr_cnt = '0;
    logic [31:0]           hdr_acc = '0;
    logic [31:0]           body_left = '0;
    logic [15:0]           args_left = '0;
    logic [15:0]           cur_idx = '0;
    logic [31:0]           data_left = '0;
    logic [MAX_LEN_W-1:0]  lim_len = MAX_LEN_RESET;
    logic [MAX_ARGS_W-1:0] lim_args = MAX_ARGS_RESET;

    result_t               expected_q[$];
    logic [7:0]            frame[$];
    int                    mismatch_count = 0;
    int                    beats_sent = 0;
    int                    stall_left = 0;
    logic                  idle_on = 1'b0;

    length_prefixed_request_deframer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Gathers one little-endian header byte; returns 1 once four are in.
    function automatic logic collect(input logic [7:0] b, output logic [31:0] word);
        hdr_acc = hdr_acc | (32'(b) << (8 * hdr_cnt));
        hdr_cnt = hdr_cnt + 2'd1;
        word = hdr_acc;
        if (hdr_cnt != 2'd0)
            return 1'b0;
        hdr_acc = '0;
        return 1'b1;
    endfunction

    // Runs after the count or an argument finished: next argument, end or error.
    function automatic status_t list_check(output logic done);
        done = 1'b0;
        if (args_left == 16'd0)
        begin
            if (body_left == 32'd0)
            begin
                done = 1'b1;
                ph = PH_LEN;
                cur_idx = '0;
                return ST_OK;
            end
            return ST_TRAILING;
        end
        if (body_left < HDR_BYTES)
            return ST_ARG_OVERRUN;
        ph = PH_ALEN;
        return ST_OK;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b, input logic rs);
        result_t r;
        logic [31:0] w;
        logic fin;
        r = '0;
        fin = 1'b0;
        if (rs)
        begin
            ph = PH_LEN;
            hdr_cnt = '0;
            hdr_acc = '0;
            body_left = '0;
            args_left = '0;
            cur_idx = '0;
            data_left = '0;
            return r;
        end
        r.arg_index = cur_idx;
        case (ph)
            PH_LEN:
                if (collect(b, w))
                begin
                    if (w > {8'h00, lim_len} || w > LEN_MAX)
                        r.status = ST_TOO_LONG;
                    else if (w < HDR_BYTES)
                        r.status = ST_TOO_SHORT;
                    else
                    begin
                        body_left = w;
                        ph = PH_CNT;
                    end
                end
            PH_CNT:
            begin
                body_left = body_left - 32'd1;
                if (collect(b, w))
                begin
                    if (w > {16'h0000, lim_args})
                        r.status = ST_TOO_MANY_ARGS;
                    else
                    begin
                        args_left = w[15:0];
                        cur_idx = '0;
                        r.status = list_check(fin);
                    end
                end
            end
            PH_ALEN:
            begin
                body_left = body_left - 32'd1;
                if (collect(b, w))
                begin
                    if (w > body_left)
                        r.status = ST_ARG_OVERRUN;
                    else if (w == 32'd0)
                    begin
                        r.arg_end = 1'b1;
                        args_left = args_left - 16'd1;
                        cur_idx = r.arg_index + 16'd1;
                        r.status = list_check(fin);
                    end
                    else
                    begin
                        data_left = w;
                        ph = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                r.data_valid = 1'b1;
                r.arg_byte = b;
                body_left = body_left - 32'd1;
                data_left = data_left - 32'd1;
                if (data_left == 32'd0)
                begin
                    r.arg_end = 1'b1;
                    args_left = args_left - 16'd1;
                    cur_idx = r.arg_index + 16'd1;
                    r.status = list_check(fin);
                end
            end
            default:
                r.status = ST_CLOSED;
        endcase
        r.request_end = fin;
        if (r.status != ST_OK)
            ph = PH_CLOSED;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Register writes, accepted input beats and result beats, all on the rising edge.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_LEN)
                    lim_len = cfg_data[MAX_LEN_W-1:0];
                else if (cfg_index == REG_MAX_ARGS)
                    lim_args = cfg_data[MAX_ARGS_W-1:0];
            end
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(), parse_byte(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing pending, expected none, got %0h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("data_valid", 32'(want.data_valid), 32'(m_tuser));
                    check_field("arg_byte", 32'(want.arg_byte), 32'(m_tdata[7:0]));
                    check_field("arg_index", 32'(want.arg_index), 32'(m_tdata[23:8]));
                    check_field("arg_end", 32'(want.arg_end), 32'(m_tlast));
                    check_field("request_end", 32'(want.request_end), 32'(m_tdata[24]));
                    check_field("status", 32'(want.status), 32'(m_tdata[27:25]));
                    check_field("pad", 32'd0, 32'(m_tdata[31:28]));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_beat(input logic [7:0] b, input logic rs);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= rs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Hold the input until every pending result beat has come out.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        frame.insert(frame.size(), b);
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < HDR_BYTES; i++)
            append_byte(w[8*i +: 8]);
    endfunction

    task automatic send_frame(input int cut);
        for (int i = 0; i < cut; i++)
            send_beat(frame[i], 1'b0);
        frame.delete();
    endtask

    // Error expected somewhere in the frame: one byte while closed, then reopen.
    task automatic send_and_restart();
        send_frame(frame.size());
        send_beat(8'($urandom), 1'b0);
        send_beat(8'($urandom), 1'b1);
    endtask

    task automatic send_request(input fault_t fault);
        int nargs;
        int body;
        int left;
        int bad;
        int cut;
        int lens[6];
        logic [31:0] len_field;
        logic [31:0] cnt_field;
        logic [31:0] alen_field;
        nargs = $urandom_range(0, 5);
        if (fault == F_NONE && nargs > lim_args)
            nargs = lim_args;
        if ((fault == F_ARG_OVERRUN || fault == F_SHORT_BODY) && nargs == 0)
            nargs = 1;
        body = HDR_BYTES;
        for (int i = 0; i < nargs; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                lens[i] = $urandom_range(7, 40);
            else
                lens[i] = $urandom_range(0, 6);
            body += HDR_BYTES + lens[i];
        end
        len_field = body;
        cnt_field = nargs;
        bad = (nargs > 0) ? $urandom_range(0, nargs - 1) : 0;
        case (fault)
            F_TOO_LONG:
                if ($urandom_range(0, 1) != 0)
                    len_field = 32'(lim_len) + $urandom_range(1, 4);
                else
                    len_field = $urandom | 32'h0100_0000;
            F_TOO_SHORT:   len_field = $urandom_range(0, 3);
            F_TOO_MANY:    cnt_field = 32'(lim_args) + $urandom_range(1, 3);
            F_SHORT_BODY:  len_field = HDR_BYTES + $urandom_range(0, body - 5);
            F_TRAILING:    len_field = body + $urandom_range(1, 5);
            default:       ;
        endcase
        frame.delete();
        push_word(len_field);
        push_word(cnt_field);
        left = body - HDR_BYTES;
        for (int i = 0; i < nargs; i++)
        begin
            left -= HDR_BYTES;
            alen_field = lens[i];
            if (fault == F_ARG_OVERRUN && i == bad)
                alen_field = left + $urandom_range(1, 4);
            push_word(alen_field);
            for (int j = 0; j < lens[i]; j++)
                append_byte(8'($urandom));
            left -= lens[i];
        end
        if (fault == F_NOISE)
        begin
            frame.delete();
            repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
        end
        cut = frame.size();
        if (fault == F_RESTART_MID)
            cut = $urandom_range(1, frame.size() - 1);
        send_frame(cut);
        // a well-formed body over a small limit also closes the link
        if (fault != F_NONE || body > lim_len)
        begin
            repeat ($urandom_range(0, 3)) send_beat(8'($urandom), 1'b0);
            send_beat(8'($urandom), 1'b1);
        end
        else if ($urandom_range(0, 5) == 0)
            send_beat(8'($urandom), 1'b1);
    endtask

    task automatic test_valid_requests();
        idle_on = 1'b0;
        send_beat(8'h5A, 1'b1);
        push_word(32'd4);
        push_word(32'd0);
        // empty argument, then three data bytes
        push_word(32'd15);
        push_word(32'd2);
        push_word(32'd0);
        push_word(32'd3);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'hA5);
        idle_on = 1'b1;
        send_frame(frame.size());
    endtask

    task automatic test_header_errors();
        push_word(32'd4097);
        send_and_restart();
        push_word(32'd3);
        send_and_restart();
        push_word(32'hFFFF_FFFF);
        send_and_restart();
        push_word(32'd8);
        push_word(32'd1025);
        send_and_restart();
    endtask

    task automatic test_argument_errors();
        // argument longer than what is left of the body
        push_word(32'd12);
        push_word(32'd1);
        push_word(32'd5);
        send_and_restart();
        // argument promised but the body ends with the count
        push_word(32'd4);
        push_word(32'd1);
        send_and_restart();
        // fewer than four body bytes left for the second argument header
        push_word(32'd10);
        push_word(32'd2);
        push_word(32'd0);
        send_and_restart();
        // body bytes left after the last argument
        push_word(32'd10);
        push_word(32'd1);
        push_word(32'd1);
        append_byte(8'h7E);
        send_and_restart();
    endtask

    task automatic test_limit_extremes();
        write_reg(REG_MAX_LEN, CFG_DATA_W'(4));
        write_reg(REG_MAX_ARGS, CFG_DATA_W'(0));
        idle_on = 1'b1;
        push_word(32'd4);
        push_word(32'd0);
        send_frame(frame.size());
        push_word(32'd5);
        send_and_restart();
        push_word(32'd8);
        push_word(32'd1);
        send_and_restart();
        write_reg(REG_MAX_LEN, CFG_DATA_W'(0));
        push_word(32'd4);
        send_and_restart();
        write_reg(REG_MAX_LEN, CFG_DATA_W'(24'hFF_FFFF));
        write_reg(REG_MAX_ARGS, CFG_DATA_W'(16'hFFFF));
        push_word(32'h00FF_FFFF);
        push_word(32'h0000_FFFF);
        push_word(32'd0);
        send_and_restart();
        push_word(32'h0100_0000);
        send_and_restart();
    endtask

    task automatic test_random_traffic();
        int first;
        int reqs;
        fault_t fault;
        logic [MAX_LEN_W-1:0] next_len;
        logic [MAX_ARGS_W-1:0] next_args;
        first = beats_sent;
        reqs = 0;
        while (beats_sent - first < 590)
        begin
            if (reqs % 8 == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       next_len = 24'hFF_FFFF;
                    1:       next_len = $urandom_range(4, 40);
                    2:       next_len = $urandom_range(0, 3);
                    default: next_len = $urandom_range(64, 24'hFF_FFFF);
                endcase
                case ($urandom_range(0, 4))
                    0:       next_args = '0;
                    1:       next_args = 16'hFFFF;
                    2:       next_args = $urandom_range(1, 3);
                    default: next_args = $urandom_range(4, 65535);
                endcase
                write_reg(REG_MAX_LEN, CFG_DATA_W'(next_len));
                write_reg(REG_MAX_ARGS, CFG_DATA_W'(next_args));
            end
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 99) < 70)
                fault = F_NONE;
            else
                fault = fault_t'($urandom_range(F_TOO_LONG, F_NOISE));
            send_request(fault);
            if (reqs % 5 == 4)
                drain();
            reqs++;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_valid_requests();
        test_header_errors();
        test_argument_errors();
        test_limit_extremes();
        test_random_traffic();
        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
